// File: rtl/dclt_pkg.sv
// Shared types, constants and the divider step for the CHS/LBA translator.
package dclt_pkg;

  localparam int unsigned CYL_W      = 16;
  localparam int unsigned HEAD_W     = 8;
  localparam int unsigned SEC_W      = 8;
  localparam int unsigned BLOCK_W    = 32;
  localparam int unsigned CYL_CNT_W  = 12;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Quotient bits resolved per divider stage.
  localparam int unsigned DIV_STEP_BITS = 4;
  localparam int unsigned DIV_STAGES    = BLOCK_W / DIV_STEP_BITS;

  typedef enum logic {
    FUNC_CHS_TO_LBA = 1'b0,
    FUNC_LBA_TO_CHS = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYL_COUNT  = 8'd0,
    REG_HEAD_COUNT = 8'd1,
    REG_SEC_NARROW = 8'd2,
    REG_SEC_WIDE   = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                func;
    logic [CYL_W-1:0]    cylinder_in;
    logic [HEAD_W-1:0]   head_in;
    logic [SEC_W-1:0]    sector_in;
    logic [BLOCK_W-1:0]  block_in;
    logic                wide_words;
  } in_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  block_out;
    logic [CYL_W-1:0]    cylinder_out;
    logic [HEAD_W-1:0]   head_out;
    logic [SEC_W-1:0]    sector_out;
    logic                address_valid;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] quo;
    logic [SEC_W-1:0]   rem;
  } div_step_t;

  // Restoring division, DIV_STEP_BITS bits. quo shifts dividend bits out
  // at the top and quotient bits in at the bottom. rem stays below dvsr.
  function automatic div_step_t div_step(logic [BLOCK_W-1:0] quo,
                                         logic [SEC_W-1:0]   rem,
                                         logic [SEC_W-1:0]   dvsr);
    div_step_t    r;
    logic [SEC_W:0] trial;
    r.quo = quo;
    r.rem = rem;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {r.rem, r.quo[BLOCK_W-1]};
      r.quo = {r.quo[BLOCK_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        trial    = trial - {1'b0, dvsr};
        r.quo[0] = 1'b1;
      end
      r.rem = trial[SEC_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/dclt_if.sv
// Valid/ready channel interfaces for request, result and register write beats.
interface dclt_in_if;
  logic               valid;
  logic               ready;
  dclt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dclt_out_if;
  logic                valid;
  logic                ready;
  dclt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dclt_cfg_if;
  logic              valid;
  logic              ready;
  dclt_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/disk_chs_lba_translate.sv
// Top level: pipelined CHS <-> LBA disk address translator.
//
// Channels: in_i takes request beats (func, cylinder/head/sector, block,
// wide_words); out_o returns one result beat per request, in order;
// cfg_i writes the geometry registers (0 cylinders, 1 heads, 2 sectors in
// narrow format, 3 sectors in wide format). cfg_i is always ready;
// unknown indexes are dropped. Geometry is expected to change only while
// no request is in flight.
// Pipeline: one entry stage, 8 stages dividing by sectors per track,
// 8 stages dividing by heads (4 quotient bits each), one output register.
// Forward requests use the first three stages after entry for c*H,
// (+h)*S and +s and then ride along. Throughput: one request per clock
// while out_o takes results. Stalls: each stage advances when it is empty
// or the stage after it moves, so bubbles collapse and in_i.ready stays
// high while any stage is free, even with a result waiting on out_o.
// Nothing is dropped or repeated.
// Reset: valid bits clear, the pipeline is empty, geometry returns to
// 815 cylinders, 19 heads, 22 / 20 sectors per track.
module disk_chs_lba_translate (
  input  logic            clk_i,
  input  logic            rst_ni,
  dclt_in_if.sink         in_i,
  dclt_out_if.source      out_o,
  dclt_cfg_if.sink        cfg_i
);
  import dclt_pkg::*;

  // Stage 0 entry, 1..DIV_STAGES divide by S, then divide by H.
  localparam int unsigned LAST_PIPE = 2 * DIV_STAGES;
  localparam int unsigned OUT_STAGE = LAST_PIPE + 1;

  typedef struct packed {
    logic                func;
    logic                fwd_ok;
    logic [CYL_W-1:0]    cyl;
    logic [HEAD_W-1:0]   head;
    logic [SEC_W-1:0]    sec;
    logic [SEC_W-1:0]    spt;
    logic [BLOCK_W-1:0]  quo;
    logic [SEC_W-1:0]    rem;
    logic [BLOCK_W-1:0]  prod;
  } pipe_t;

  // ---------------- geometry registers ----------------
  logic [CYL_CNT_W-1:0] cyl_cnt_q;
  logic [HEAD_W-1:0]    head_cnt_q;
  logic [SEC_W-1:0]     sec_narrow_q;
  logic [SEC_W-1:0]     sec_wide_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyl_cnt_q    <= CYL_CNT_W'(815);
      head_cnt_q   <= HEAD_W'(19);
      sec_narrow_q <= SEC_W'(22);
      sec_wide_q   <= SEC_W'(20);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_CYL_COUNT:  cyl_cnt_q    <= cfg_i.data.value[CYL_CNT_W-1:0];
        REG_HEAD_COUNT: head_cnt_q   <= cfg_i.data.value[HEAD_W-1:0];
        REG_SEC_NARROW: sec_narrow_q <= cfg_i.data.value[SEC_W-1:0];
        REG_SEC_WIDE:   sec_wide_q   <= cfg_i.data.value[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage advance ----------------
  logic [OUT_STAGE:0] valid_q;
  logic [OUT_STAGE:0] adv;

  // A stage moves when it holds nothing or its successor moves.
  always_comb begin
    adv[OUT_STAGE] = ~valid_q[OUT_STAGE] | out_o.ready;
    for (int k = OUT_STAGE - 1; k >= 0; k--) begin
      adv[k] = ~valid_q[k] | adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_i.valid;
      end
      for (int k = 1; k <= OUT_STAGE; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------- datapath ----------------
  pipe_t pipe_d [LAST_PIPE+1];
  pipe_t pipe_q [LAST_PIPE+1];

  for (genvar k = 0; k <= LAST_PIPE; k++) begin : g_stage
    if (k == 0) begin : g_entry
      // Select S, range-check the forward address, load the dividend.
      always_comb begin
        pipe_d[k].func   = in_i.data.func;
        pipe_d[k].cyl    = in_i.data.cylinder_in;
        pipe_d[k].head   = in_i.data.head_in;
        pipe_d[k].sec    = in_i.data.sector_in;
        pipe_d[k].spt    = in_i.data.wide_words ? sec_wide_q : sec_narrow_q;
        pipe_d[k].fwd_ok = (in_i.data.cylinder_in < {{(CYL_W-CYL_CNT_W){1'b0}}, cyl_cnt_q})
                         && (in_i.data.head_in < head_cnt_q)
                         && (in_i.data.sector_in < pipe_d[k].spt);
        pipe_d[k].quo    = in_i.data.block_in;
        pipe_d[k].rem    = '0;
        pipe_d[k].prod   = '0;
      end
    end else if (k == 1) begin : g_mul_head
      div_step_t           dv;
      logic [CYL_W+HEAD_W-1:0] cyl_x_head;
      assign dv         = div_step(pipe_q[k-1].quo, pipe_q[k-1].rem, pipe_q[k-1].spt);
      assign cyl_x_head = pipe_q[k-1].cyl * head_cnt_q;
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].quo  = dv.quo;
        pipe_d[k].rem  = dv.rem;
        pipe_d[k].prod = {{(BLOCK_W-CYL_W-HEAD_W){1'b0}}, cyl_x_head};
      end
    end else if (k == 2) begin : g_mul_sec
      div_step_t          dv;
      logic [BLOCK_W:0]   trk_x_sec;
      assign dv        = div_step(pipe_q[k-1].quo, pipe_q[k-1].rem, pipe_q[k-1].spt);
      // Track index fits in 25 bits; the product is only used when valid,
      // and then it fits in 32.
      assign trk_x_sec = ({1'b0, pipe_q[k-1].prod} + (BLOCK_W+1)'(pipe_q[k-1].head))
                       * (BLOCK_W+1)'(pipe_q[k-1].spt);
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].quo  = dv.quo;
        pipe_d[k].rem  = dv.rem;
        pipe_d[k].prod = trk_x_sec[BLOCK_W-1:0];
      end
    end else if (k == 3) begin : g_add_sec
      div_step_t dv;
      assign dv = div_step(pipe_q[k-1].quo, pipe_q[k-1].rem, pipe_q[k-1].spt);
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].quo  = dv.quo;
        pipe_d[k].rem  = dv.rem;
        pipe_d[k].prod = pipe_q[k-1].prod + BLOCK_W'(pipe_q[k-1].sec);
      end
    end else if (k <= DIV_STAGES) begin : g_div_spt
      div_step_t dv;
      assign dv = div_step(pipe_q[k-1].quo, pipe_q[k-1].rem, pipe_q[k-1].spt);
      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].quo = dv.quo;
        pipe_d[k].rem = dv.rem;
      end
    end else if (k == DIV_STAGES + 1) begin : g_div_head_first
      // Park b mod S in the sector slot and restart the remainder.
      div_step_t dv;
      assign dv = div_step(pipe_q[k-1].quo, '0, head_cnt_q);
      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].sec = pipe_q[k-1].rem;
        pipe_d[k].quo = dv.quo;
        pipe_d[k].rem = dv.rem;
      end
    end else begin : g_div_head
      div_step_t dv;
      assign dv = div_step(pipe_q[k-1].quo, pipe_q[k-1].rem, head_cnt_q);
      always_comb begin
        pipe_d[k]     = pipe_q[k-1];
        pipe_d[k].quo = dv.quo;
        pipe_d[k].rem = dv.rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= LAST_PIPE; k++) begin
      if (adv[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // ---------------- result assembly ----------------
  pipe_t     fin;
  logic      rev_ok;
  out_item_t out_d;
  out_item_t out_q;

  assign fin = pipe_q[LAST_PIPE];

  // quo is the cylinder, rem the head, sec the sector. Zero S or H leaves
  // the divider output meaningless, so those mark the address invalid.
  assign rev_ok = (fin.spt != '0) && (head_cnt_q != '0)
               && (fin.quo < {{(BLOCK_W-CYL_CNT_W){1'b0}}, cyl_cnt_q});

  always_comb begin
    out_d = '0;
    if (func_e'(fin.func) == FUNC_CHS_TO_LBA) begin
      out_d.block_out     = fin.fwd_ok ? fin.prod : '1;
      out_d.address_valid = fin.fwd_ok;
    end else begin
      out_d.cylinder_out  = rev_ok ? fin.quo[CYL_W-1:0] : '1;
      out_d.head_out      = rev_ok ? fin.rem : '1;
      out_d.sector_out    = rev_ok ? fin.sec : '1;
      out_d.address_valid = rev_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OUT_STAGE]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = valid_q[OUT_STAGE];
  assign out_o.data  = out_q;

  // ---------------- checks ----------------
  // A free slot anywhere in the pipe means a new request can enter.
  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> in_i.ready)
    else $error("input stalled with a free pipeline slot");

  // Good forward blocks never reach all ones; reverse beats carry block 0.
  a_valid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.address_valid |-> out_o.data.block_out != '1)
    else $error("valid result carries the invalid block marker");

  // An invalid result carries the marker on the side it converted to.
  a_invalid_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.address_valid |->
      (out_o.data.block_out == '1) ||
      (out_o.data.cylinder_out == '1 && out_o.data.head_out == '1 &&
       out_o.data.sector_out == '1))
    else $error("invalid result without all-ones marker");

  // A stalled result stays in the output register.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_q))
    else $error("stalled result lost or changed");

endmodule

// File: sim/disk_chs_lba_translate_test.sv
// Testbench for the CHS/LBA disk address translator: self-checking, random stalls.
module disk_chs_lba_translate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dclt_pkg::*;

  // The drain after the last result is twice DUT_LATENCY, the least time from request
  // accept to result accept.
  localparam int unsigned DUT_LATENCY = 18;
  localparam int unsigned DRAIN_CYCLES = 2 * DUT_LATENCY;
  // 30 items per pass when a geometry is zero, 60 to 80 otherwise.
  localparam int unsigned NUM_PASSES = 10;

  logic clk_i;
  logic rst_ni;

  dclt_in_if  req_if ();
  dclt_out_if rsp_if ();
  dclt_cfg_if cfg_if ();

  disk_chs_lba_translate u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Our copy of the geometry registers. It is updated on each accepted write beat.
  logic [CYL_CNT_W-1:0] geo_cyl;
  logic [HEAD_W-1:0]    geo_heads;
  logic [SEC_W-1:0]     geo_sec_narrow;
  logic [SEC_W-1:0]     geo_sec_wide;

  in_item_t  pending_requests[$];   // waiting for the request driver
  out_item_t expected_results[$];   // predicted at request accept, oldest first
  cfg_wr_t   pending_writes[$];     // register writes waiting for the config driver

  int unsigned requests_queued;
  int unsigned results_checked;
  int unsigned cfg_queued;
  int unsigned cfg_written;
  int unsigned mismatches;
  int unsigned req_gap;             // idle cycles left before the next request beat
  int unsigned rsp_stall;           // cycles left with result ready held low
  logic        idle_en;             // idle bursts allowed in this pass

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The limit below is well above the longest correct run.
  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Expected-result calculation
  // ---------------------------------------------------------------------------
  // Forward: (c*H + h)*S + s when c, h and s are each below their count. Otherwise the
  // block is all ones. Reverse: split by S and then by H. A cylinder past the count,
  // or a zero divisor, gives all-ones CHS. The fields of the other direction read 0.
  function automatic out_item_t predict_translation(in_item_t req);
    out_item_t   res;
    logic [31:0] spt;
    logic [31:0] heads;
    logic [31:0] trk;
    logic [31:0] cyl;
    logic        ok;
    res   = '0;
    ok    = 1'b0;
    trk   = '0;
    cyl   = '0;
    spt   = req.wide_words ? 32'(geo_sec_wide) : 32'(geo_sec_narrow);
    heads = 32'(geo_heads);
    if (req.func == FUNC_CHS_TO_LBA) begin
      ok = (32'(req.cylinder_in) < 32'(geo_cyl)) && (32'(req.head_in) < heads) &&
           (32'(req.sector_in) < spt);
      res.block_out = ok ? (32'(req.cylinder_in) * heads + 32'(req.head_in)) * spt +
                           32'(req.sector_in) : '1;
    end else begin
      if (spt != 0 && heads != 0) begin
        trk = req.block_in / spt;
        cyl = trk / heads;
        ok  = cyl < 32'(geo_cyl);
      end
      if (ok) begin
        res.cylinder_out = cyl[CYL_W-1:0];
        res.head_out     = HEAD_W'(trk % heads);
        res.sector_out   = SEC_W'(req.block_in % spt);
      end else begin
        res.cylinder_out = '1;
        res.head_out     = '1;
        res.sector_out   = '1;
      end
    end
    res.address_valid = ok;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  // The unused fields of the other direction get random values, which the block
  // must ignore.
  function automatic in_item_t make_fwd(logic [CYL_W-1:0] c, logic [HEAD_W-1:0] h,
                                        logic [SEC_W-1:0] s, logic wide);
    in_item_t req;
    req.func        = FUNC_CHS_TO_LBA;
    req.cylinder_in = c;
    req.head_in     = h;
    req.sector_in   = s;
    req.block_in    = $urandom;
    req.wide_words  = wide;
    return req;
  endfunction

  function automatic in_item_t make_rev(logic [BLOCK_W-1:0] b, logic wide);
    in_item_t req;
    req.func        = FUNC_LBA_TO_CHS;
    req.cylinder_in = CYL_W'($urandom);
    req.head_in     = HEAD_W'($urandom);
    req.sector_in   = SEC_W'($urandom);
    req.block_in    = b;
    req.wide_words  = wide;
    return req;
  endfunction

  // Pick a value below lim. The edges 0 and lim-1 come up often. A zero limit
  // gives any value.
  function automatic logic [31:0] pick_below(logic [31:0] lim);
    if (lim == 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return lim - 1;
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  // Most requests are in range for the current geometry, in either direction.
  // The others go at or past a limit or are fully random.
  function automatic in_item_t random_request();
    in_item_t    req;
    logic [31:0] spt;
    logic [31:0] span;
    int unsigned pick;
    req.func        = 1'($urandom_range(0, 1));
    req.cylinder_in = CYL_W'($urandom);
    req.head_in     = HEAD_W'($urandom);
    req.sector_in   = SEC_W'($urandom);
    req.block_in    = $urandom;
    req.wide_words  = 1'($urandom_range(0, 1));
    spt  = req.wide_words ? 32'(geo_sec_wide) : 32'(geo_sec_narrow);
    span = 32'(geo_cyl) * 32'(geo_heads) * spt;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      req.func        = FUNC_CHS_TO_LBA;
      req.cylinder_in = CYL_W'(pick_below(32'(geo_cyl)));
      req.head_in     = HEAD_W'(pick_below(32'(geo_heads)));
      req.sector_in   = SEC_W'(pick_below(spt));
      // One field at or past its count
      if (pick >= 8) begin
        case ($urandom_range(0, 2))
          0:       req.cylinder_in = CYL_W'($urandom_range(32'(geo_cyl), 32'hFFFF));
          1:       req.head_in = HEAD_W'($urandom_range(32'(geo_heads), 32'hFF));
          default: req.sector_in = SEC_W'($urandom_range(spt, 32'hFF));
        endcase
      end
    end else if (pick < 17) begin
      req.func     = FUNC_LBA_TO_CHS;
      req.block_in = pick_below(span);
    end else if (pick == 17) begin
      req.func     = FUNC_LBA_TO_CHS;
      req.block_in = span + $urandom_range(0, 5000);
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(in_item_t req);
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_t wr;
    wr.index = idx;
    wr.value = val;
    pending_writes.push_back(wr);
    cfg_queued++;
  endtask

  // Counters instead of the queue sizes: the drivers pop a queue when they drive the beat,
  // before it is accepted.
  task automatic wait_idle();
    while (requests_queued != results_checked || cfg_queued != cfg_written)
      @(posedge clk_i);
  endtask

  // Writes all four registers, then a write to an unknown index that the block must
  // drop. Bits above each register's width are kept as given. The block masks them.
  task automatic set_geometry(logic [CFG_DATA_W-1:0] cyls, logic [CFG_DATA_W-1:0] heads,
                              logic [CFG_DATA_W-1:0] sec_n, logic [CFG_DATA_W-1:0] sec_w);
    write_reg(REG_CYL_COUNT, cyls);
    write_reg(REG_HEAD_COUNT, heads);
    write_reg(REG_SEC_NARROW, sec_n);
    write_reg(REG_SEC_WIDE, sec_w);
    write_reg(CFG_IDX_W'(REG_SEC_WIDE) + CFG_IDX_W'($urandom_range(1, 252)),
              CFG_DATA_W'($urandom));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // Computes the expectation for each accepted beat. Valid stays high across
  // back-to-back beats. An idle burst may follow any beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        expected_results.push_back(predict_translation(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_requests.pop_front();
          if (idle_en && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 13);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          REG_CYL_COUNT:  geo_cyl = cfg_if.data.value[CYL_CNT_W-1:0];
          REG_HEAD_COUNT: geo_heads = cfg_if.data.value[HEAD_W-1:0];
          REG_SEC_NARROW: geo_sec_narrow = cfg_if.data.value[SEC_W-1:0];
          REG_SEC_WIDE:   geo_sec_wide = cfg_if.data.value[SEC_W-1:0];
          default: ;  // unknown index: dropped
        endcase
        cfg_written++;
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (pending_writes.size() != 0) begin
          cfg_if.valid <= 1'b1;
          cfg_if.data  <= pending_writes.pop_front();
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and checker
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing expected, expected none, got %0h",
                   $time, rsp_if.data);
        end else begin
          want = expected_results.pop_front();
          check_field("block_out", want.block_out, rsp_if.data.block_out);
          check_field("cylinder_out", 32'(want.cylinder_out), 32'(rsp_if.data.cylinder_out));
          check_field("head_out", 32'(want.head_out), 32'(rsp_if.data.head_out));
          check_field("sector_out", 32'(want.sector_out), 32'(rsp_if.data.sector_out));
          check_field("address_valid", 32'(want.address_valid),
                      32'(rsp_if.data.address_valid));
          results_checked++;
        end
      end
      // Back-pressure bursts. Ready may drop while a result is waiting.
      if (rsp_stall != 0) rsp_stall--;
      else if (idle_en && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 13);
      rsp_if.ready <= (rsp_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    // Reset geometry
    geo_cyl         = CYL_CNT_W'(815);
    geo_heads       = HEAD_W'(19);
    geo_sec_narrow  = SEC_W'(22);
    geo_sec_wide    = SEC_W'(20);
    requests_queued = 0;
    results_checked = 0;
    cfg_queued      = 0;
    cfg_written     = 0;
    mismatches      = 0;
    req_gap         = 0;
    rsp_stall       = 0;
    idle_en         = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks on the reset geometry: 815 x 19 x 22 (narrow), 20 (wide)
    queue_request(make_fwd(16'd0, 8'd0, 8'd0, 1'b0));
    queue_request(make_fwd(16'd814, 8'd18, 8'd21, 1'b0));     // last narrow block
    queue_request(make_fwd(16'd814, 8'd18, 8'd19, 1'b1));     // last wide block
    queue_request(make_fwd(16'd815, 8'd0, 8'd0, 1'b0));       // cylinder at count
    queue_request(make_fwd(16'd0, 8'd19, 8'd0, 1'b0));        // head at count
    queue_request(make_fwd(16'd0, 8'd0, 8'd22, 1'b0));        // sector at narrow count
    queue_request(make_fwd(16'd0, 8'd0, 8'd20, 1'b1));        // fine narrow, bad wide
    queue_request(make_fwd(16'd0, 8'd0, 8'd21, 1'b1));
    queue_request(make_fwd(16'hFFFF, 8'hFF, 8'hFF, 1'b1));    // all fields at max
    queue_request(make_fwd(16'd3, 8'd7, 8'd11, 1'b0));
    queue_request(make_rev(32'd0, 1'b0));
    queue_request(make_rev(32'd0, 1'b1));
    queue_request(make_rev(32'd340669, 1'b0));                // last narrow block
    queue_request(make_rev(32'd340670, 1'b0));                // one past the end
    queue_request(make_rev(32'd309699, 1'b1));                // last wide block
    queue_request(make_rev(32'd309700, 1'b1));
    queue_request(make_rev(32'hFFFF_FFFF, 1'b0));
    queue_request(make_rev(32'hFFFF_FFFF, 1'b1));
    queue_request(make_rev(32'd21, 1'b0));                    // sector wrap
    queue_request(make_rev(32'd22, 1'b0));                    // head carry
    queue_request(make_rev(32'd418, 1'b0));                   // cylinder carry
    wait_idle();

    // Random passes, each on its own geometry
    for (int pass_no = 0; pass_no < NUM_PASSES; pass_no++) begin
      n = 70;
      case (pass_no)
        0: set_geometry(16'd4095, 16'd255, 16'd255, 16'd255);
        1: begin
          set_geometry(16'd1, 16'd1, 16'd1, 16'd1);
          n = 60;
        end
        // Masked writes. The head count becomes 0, so every address is invalid.
        6: begin
          set_geometry(16'hF064, 16'hFF00, 16'h0A11, 16'h550D);
          n = 30;
        end
        // Zero sectors in the narrow format only
        7: begin
          set_geometry(16'd500, 16'd12, 16'h0100, 16'h3F07);
          n = 30;
        end
        // Zero cylinders
        8: begin
          set_geometry(16'h7000, 16'd4, 16'd9, 16'd17);
          n = 30;
        end
        9: begin
          set_geometry(CFG_DATA_W'($urandom_range(1, 4095)), CFG_DATA_W'($urandom_range(1, 255)),
                       CFG_DATA_W'($urandom_range(1, 255)), CFG_DATA_W'($urandom_range(1, 255)));
          n = 80;
        end
        default: set_geometry(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 255)),
                              CFG_DATA_W'($urandom_range(1, 255)),
                              CFG_DATA_W'($urandom_range(1, 255)));
      endcase
      // Last pass runs at full rate on both sides
      idle_en = (pass_no == NUM_PASSES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (n) queue_request(random_request());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
